### rtl/pse_pkg.sv
// pse_pkg: shared types, defaults and the sector unit-vector table
// for the pie sector pixel eraser; no dependencies
package pse_pkg;

	localparam int FRAME_WIDTH_DEF  = 400;
	localparam int FRAME_HEIGHT_DEF = 400;
	localparam int MAX_SECTORS_DEF  = 9;
	localparam int VEC_ROWS         = 9;

	// unit vectors scaled by 1000, one row per sector count (row = count - 1)
	localparam int VEC_X [0:VEC_ROWS-1][0:VEC_ROWS-1] = '{
		'{   0,    0,    0,    0,    0,    0,    0,    0,    0},
		'{   0,    0,    0,    0,    0,    0,    0,    0,    0},
		'{   0,  866, -866,    0,    0,    0,    0,    0,    0},
		'{   0, 1000,    0,-1000,    0,    0,    0,    0,    0},
		'{   0,  951,  588, -588, -951,    0,    0,    0,    0},
		'{   0,  866,  866,    0, -866, -866,    0,    0,    0},
		'{   0,  782,  975,  434, -434, -975, -782,    0,    0},
		'{   0,  707, 1000,  707,    0, -707,-1000, -707,    0},
		'{   0,  643,  985,  866,  342, -342, -866, -985, -643}
	};

	localparam int VEC_Y [0:VEC_ROWS-1][0:VEC_ROWS-1] = '{
		'{-1000,    0,    0,    0,    0,    0,    0,    0,    0},
		'{-1000, 1000,    0,    0,    0,    0,    0,    0,    0},
		'{-1000,  500,  500,    0,    0,    0,    0,    0,    0},
		'{-1000,    0, 1000,    0,    0,    0,    0,    0,    0},
		'{-1000, -309,  809,  809, -309,    0,    0,    0,    0},
		'{-1000, -500,  500, 1000,  500, -500,    0,    0,    0},
		'{-1000, -623,  223,  901,  901,  223, -623,    0,    0},
		'{-1000, -707,    0,  707, 1000,  707,    0, -707,    0},
		'{-1000, -766, -174,  500,  940,  940,  500, -174, -766}
	};

	// token handed from cell to cell
	typedef struct packed {
		logic               in_disc;
		logic signed [9:0]  dx;
		logic signed [9:0]  dy;
		logic [3:0]         color;
		logic signed [21:0] lead_dot;
		logic [3:0]         best_idx;
	} tok_t;

	function automatic logic signed [10:0] vec_x(input logic [3:0] row, input logic [3:0] idx);
		logic signed [10:0] v;
		v = '0;
		if (row < 4'(VEC_ROWS) && idx < 4'(VEC_ROWS))
			v = 11'(VEC_X[row][idx]);
		return v;
	endfunction

	function automatic logic signed [10:0] vec_y(input logic [3:0] row, input logic [3:0] idx);
		logic signed [10:0] v;
		v = '0;
		if (row < 4'(VEC_ROWS) && idx < 4'(VEC_ROWS))
			v = 11'(VEC_Y[row][idx]);
		return v;
	endfunction

endpackage

### rtl/pse_front.sv
// pse_front: offset from center, frame check and disc test (two stages)
// depends on pse_pkg
module pse_front #(
	parameter int FRAME_WIDTH  = pse_pkg::FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = pse_pkg::FRAME_HEIGHT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [8:0]    px,
	input  logic [8:0]    py,
	input  logic [3:0]    color,
	input  logic [8:0]    cx,
	input  logic [8:0]    cy,
	input  logic [17:0]   rsq,
	output logic          out_vld,
	output pse_pkg::tok_t out_tok
);
	import pse_pkg::*;

	logic              valid_s1;
	logic              in_frame_s1;
	logic signed [9:0] dx_s1;
	logic signed [9:0] dy_s1;
	logic [3:0]        color_s1;

	logic              valid_s2;
	tok_t              tok_s2;

	logic signed [20:0] dxe;
	logic signed [20:0] dye;
	logic signed [20:0] dsq;

	assign dxe = 21'(dx_s1);
	assign dye = 21'(dy_s1);
	assign dsq = dxe * dxe + dye * dye;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_vld;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_frame_s1 <= ({2'b00, px} < 11'(FRAME_WIDTH)) && ({2'b00, py} < 11'(FRAME_HEIGHT));
			dx_s1       <= $signed({1'b0, px}) - $signed({1'b0, cx});
			dy_s1       <= $signed({1'b0, py}) - $signed({1'b0, cy});
			color_s1    <= color;

			tok_s2.in_disc  <= in_frame_s1 && (unsigned'(dsq) <= {3'b000, rsq});
			tok_s2.dx       <= dx_s1;
			tok_s2.dy       <= dy_s1;
			tok_s2.color    <= color_s1;
			tok_s2.lead_dot <= '0;
			tok_s2.best_idx <= '0;
		end
	end

	assign out_vld = valid_s2;
	assign out_tok = tok_s2;

endmodule

### rtl/pse_cell.sv
// pse_cell: one sector candidate; dot product against its vector, keeps the best
// depends on pse_pkg
module pse_cell #(
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [3:0]    row,
	input  logic          in_vld,
	input  pse_pkg::tok_t in_tok,
	output logic          out_vld,
	output pse_pkg::tok_t out_tok
);
	import pse_pkg::*;

	localparam logic [3:0] CELL_IDX = 4'(IDX);

	logic signed [21:0] vxw;
	logic signed [21:0] vyw;
	logic signed [21:0] dot;
	logic               take;
	logic               valid_q;
	tok_t               tok_d;
	tok_t               tok_q;

	assign vxw = 22'(vec_x(row, CELL_IDX));
	assign vyw = 22'(vec_y(row, CELL_IDX));
	assign dot = 22'(in_tok.dx) * vxw + 22'(in_tok.dy) * vyw;

	// first cell seeds the running best, later ones win only on strictly greater
	always_comb begin
		if (IDX == 0)
			take = 1'b1;
		else
			take = (CELL_IDX <= row) && (dot > in_tok.lead_dot);
	end

	always_comb begin
		tok_d = in_tok;
		if (take) begin
			tok_d.lead_dot = dot;
			tok_d.best_idx = CELL_IDX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (en)
			valid_q <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en)
			tok_q <= tok_d;
	end

	assign out_vld = valid_q;
	assign out_tok = tok_q;

endmodule

### rtl/pie_sector_pixel_eraser.sv
// pie_sector_pixel_eraser: top level; config registers, front stages,
// chain of sector cells and the output register; depends on pse_pkg, pse_front, pse_cell
//
//  channel  | signals                                          | direction
//  ---------+--------------------------------------------------+----------
//  pixel in | in_valid, in_ready, pixel_x, pixel_y, color_in   | in
//  result   | out_valid, out_ready, color_out, inside_disc,    | out
//           | sector_index, was_erased                         |
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data        | in
//
// one pixel per clock sustained unless the output stalls; the stages in order:
// two front stages, one cell per sector, then the output register
// the whole pipeline advances together; when out_valid is high and out_ready low
// every stage holds and in_ready drops in the same cycle
// reset loads the config defaults and empties the pipeline; nothing to clear
// config transfers are always taken (cfg_ready is tied high)
module pie_sector_pixel_eraser #(
	parameter int FRAME_WIDTH  = pse_pkg::FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = pse_pkg::FRAME_HEIGHT_DEF,
	parameter int MAX_SECTORS  = pse_pkg::MAX_SECTORS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// pixel input
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [8:0] pixel_x,
	input  logic [8:0] pixel_y,
	input  logic [3:0] color_in,
	// result output
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] color_out,
	output logic       inside_disc,
	output logic [3:0] sector_index,
	output logic       was_erased,
	// config writes
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [8:0] cfg_data
);
	import pse_pkg::*;

	// register indexes
	localparam logic [2:0] CFG_SECTOR_COUNT = 3'd0;
	localparam logic [2:0] CFG_EATEN        = 3'd1;
	localparam logic [2:0] CFG_CENTER_X     = 3'd2;
	localparam logic [2:0] CFG_CENTER_Y     = 3'd3;
	localparam logic [2:0] CFG_RADIUS       = 3'd4;
	localparam logic [2:0] CFG_ERASE_COLOR  = 3'd5;

	logic [3:0]  sector_count_q;
	logic [3:0]  eaten_q;
	logic [8:0]  center_x_q;
	logic [8:0]  center_y_q;
	logic [8:0]  radius_q;
	logic [3:0]  erase_color_q;
	logic [17:0] rsq_q;

	logic       en;
	logic [3:0] eff_cnt;
	logic [3:0] row;

	logic chain_vld [0:MAX_SECTORS];
	tok_t chain_tok [0:MAX_SECTORS];

	logic       out_valid_q;
	logic [3:0] color_out_q;
	logic       inside_q;
	logic [3:0] sector_q;
	logic       erased_q;

	logic [3:0] fin_sector;
	logic       fin_erased;

	// ---------------- config ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_count_q <= 4'd6;
			eaten_q        <= 4'd0;
			center_x_q     <= 9'd200;
			center_y_q     <= 9'd200;
			radius_q       <= 9'd188;
			erase_color_q  <= 4'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SECTOR_COUNT: sector_count_q <= cfg_data[3:0];
				CFG_EATEN:        eaten_q        <= cfg_data[3:0];
				CFG_CENTER_X:     center_x_q     <= cfg_data;
				CFG_CENTER_Y:     center_y_q     <= cfg_data;
				CFG_RADIUS:       radius_q       <= cfg_data;
				CFG_ERASE_COLOR:  erase_color_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// squared radius, refreshed every cycle; settles long before a pixel reaches the test
	always_ff @(posedge clk) begin
		rsq_q <= 18'(radius_q) * 18'(radius_q);
	end

	// zero counts as one, large counts saturate
	always_comb begin
		if (sector_count_q == 4'd0)
			eff_cnt = 4'd1;
		else if (sector_count_q > 4'(MAX_SECTORS))
			eff_cnt = 4'(MAX_SECTORS);
		else
			eff_cnt = sector_count_q;
	end
	assign row = eff_cnt - 4'd1;

	// ---------------- flow control ----------------
	// global advance: moves whenever the output register is free or being drained
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// ---------------- front stages ----------------
	pse_front #(
		.FRAME_WIDTH (FRAME_WIDTH),
		.FRAME_HEIGHT(FRAME_HEIGHT)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (in_valid),
		.px     (pixel_x),
		.py     (pixel_y),
		.color  (color_in),
		.cx     (center_x_q),
		.cy     (center_y_q),
		.rsq    (rsq_q),
		.out_vld(chain_vld[0]),
		.out_tok(chain_tok[0])
	);

	// ---------------- sector cells ----------------
	for (genvar i = 0; i < MAX_SECTORS; i++) begin : g_cell
		pse_cell #(
			.IDX(i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.row    (row),
			.in_vld (chain_vld[i]),
			.in_tok (chain_tok[i]),
			.out_vld(chain_vld[i+1]),
			.out_tok(chain_tok[i+1])
		);
	end

	// ---------------- output register ----------------
	// outside pixels report sector zero and never erase
	assign fin_sector = chain_tok[MAX_SECTORS].in_disc ? chain_tok[MAX_SECTORS].best_idx : 4'd0;
	assign fin_erased = chain_tok[MAX_SECTORS].in_disc && (fin_sector < eaten_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= chain_vld[MAX_SECTORS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			color_out_q <= fin_erased ? erase_color_q : chain_tok[MAX_SECTORS].color;
			inside_q    <= chain_tok[MAX_SECTORS].in_disc;
			sector_q    <= fin_sector;
			erased_q    <= fin_erased;
		end
	end

	assign out_valid    = out_valid_q;
	assign color_out    = color_out_q;
	assign inside_disc  = inside_q;
	assign sector_index = sector_q;
	assign was_erased   = erased_q;

	// ---------------- checks ----------------
	// a pixel outside the disc reports sector zero and is not erased
	a_outside_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !inside_disc) |-> (sector_index == 4'd0 && !was_erased))
		else $error("outside pixel carries sector or erase");

	// an erased pixel carries the erase color and an eaten sector
	a_erase_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && was_erased) |-> (color_out == erase_color_q && sector_index < eaten_q))
		else $error("erased pixel inconsistent with config");

	// the winning sector is always one of the active sectors
	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && inside_disc) |-> (sector_index < eff_cnt))
		else $error("sector index beyond active count");

	// an inside pixel of a non-eaten sector is not erased
	a_keep_color: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && inside_disc && sector_index >= eaten_q) |-> !was_erased)
		else $error("non-eaten sector erased");

	// stall holds the input side
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("input accepted during output stall");

endmodule

### tb/tb_top.sv
// tb_top: self-checking bench for the pie sector pixel eraser; streams pixels through
// the valid/ready channels and predicts every result in the bench itself
// depends on pse_pkg and pie_sector_pixel_eraser
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pse_pkg::*;

	localparam int FRAME_W     = FRAME_WIDTH_DEF;
	localparam int FRAME_H     = FRAME_HEIGHT_DEF;
	localparam int SECTORS_MAX = MAX_SECTORS_DEF;
	localparam int LATENCY     = MAX_SECTORS_DEF + 3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTING_LEN = 122;

	// config register indexes as seen on cfg_index
	typedef enum logic [2:0] {
		REG_SECTOR_COUNT = 3'd0,
		REG_EATEN        = 3'd1,
		REG_CENTER_X     = 3'd2,
		REG_CENTER_Y     = 3'd3,
		REG_RADIUS       = 3'd4,
		REG_ERASE_COLOR  = 3'd5,
		REG_UNUSED_6     = 3'd6,
		REG_UNUSED_7     = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic [3:0] color;
		logic       in_disc;
		logic [3:0] sector;
		logic       erased;
	} pixel_result_t;

	// unit vectors scaled by 1000, packed as a triangle:
	// the vectors for a count of n start at entry n*(n-1)/2
	localparam int DIR_X [0:44] = '{
		0,                                          // one sector
		0, 0,                                       // two
		0, 866, -866,                               // three
		0, 1000, 0, -1000,                          // four
		0, 951, 588, -588, -951,                    // five
		0, 866, 866, 0, -866, -866,                 // six
		0, 782, 975, 434, -434, -975, -782,         // seven
		0, 707, 1000, 707, 0, -707, -1000, -707,    // eight
		0, 643, 985, 866, 342, -342, -866, -985, -643
	};
	localparam int DIR_Y [0:44] = '{
		-1000,
		-1000, 1000,
		-1000, 500, 500,
		-1000, 0, 1000, 0,
		-1000, -309, 809, 809, -309,
		-1000, -500, 500, 1000, 500, -500,
		-1000, -623, 223, 901, 901, 223, -623,
		-1000, -707, 0, 707, 1000, 707, 0, -707,
		-1000, -766, -174, 500, 940, 940, 500, -174, -766
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [8:0] pixel_x = '0;
	logic [8:0] pixel_y = '0;
	logic [3:0] color_in = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [3:0] color_out;
	logic       inside_disc;
	logic [3:0] sector_index;
	logic       was_erased;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [8:0] cfg_data = '0;

	// mirror of the config registers, reset values
	logic [3:0] cur_sectors = 4'd6;
	logic [3:0] cur_eaten   = 4'd0;
	logic [8:0] cur_cx      = 9'd200;
	logic [8:0] cur_cy      = 9'd200;
	logic [8:0] cur_radius  = 9'd188;
	logic [3:0] cur_erase   = 4'd1;

	pixel_result_t pending_results[$];
	int            error_count = 0;
	int            cycle_count = 0;
	int            idle_pct = 0;
	int            stall_pct = 0;

	pie_sector_pixel_eraser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.color_in     (color_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.color_out    (color_out),
		.inside_disc  (inside_disc),
		.sector_index (sector_index),
		.was_erased   (was_erased),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// what the block should do to one pixel under the current settings
	function automatic pixel_result_t erase_pixel(logic [8:0] x, logic [8:0] y,
			logic [3:0] c);
		pixel_result_t res;
		int dx, dy, rad, n, base, k, dot, lead_dot;
		logic [3:0] best;
		res = '{color: c, in_disc: 1'b0, sector: 4'd0, erased: 1'b0};
		// off-frame pixels pass untouched, like pixels outside the disc
		if (int'(x) < FRAME_W && int'(y) < FRAME_H) begin
			dx = int'(x) - int'(cur_cx);
			dy = int'(y) - int'(cur_cy);
			rad = int'(cur_radius);
			if (dx * dx + dy * dy <= rad * rad) begin
				// a count of zero acts as one, anything past the table saturates
				n = int'(cur_sectors);
				if (n < 1)
					n = 1;
				if (n > SECTORS_MAX)
					n = SECTORS_MAX;
				base = n * (n - 1) / 2;
				best = 4'd0;
				lead_dot = dx * DIR_X[base] + dy * DIR_Y[base];
				// strict compare keeps the lower index on a tie
				for (k = 1; k < n; k++) begin
					dot = dx * DIR_X[base + k] + dy * DIR_Y[base + k];
					if (dot > lead_dot) begin
						lead_dot = dot;
						best = 4'(k);
					end
				end
				res.in_disc = 1'b1;
				res.sector = best;
				if (best < cur_eaten) begin
					res.erased = 1'b1;
					res.color = cur_erase;
				end
			end
		end
		return res;
	endfunction

	task automatic compare_field(string what, int want, int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what,
				want, got);
			error_count++;
		end
	endtask

	// result side: check every transfer against the oldest prediction, then
	// decide whether to stall the next cycle
	always @(posedge clk) begin
		pixel_result_t want;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: result with nothing predicted, expected none, actual color %0d",
					$time, color_out);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("color_out", want.color, color_out);
				compare_field("inside_disc", want.in_disc, inside_disc);
				compare_field("sector_index", want.sector, sector_index);
				compare_field("was_erased", want.erased, was_erased);
			end
		end
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// one pixel transfer; entered and left right after a rising edge
	task automatic send_pixel(logic [8:0] x, logic [8:0] y, logic [3:0] c);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_x <= x;
		pixel_y <= y;
		color_in <= c;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(erase_pixel(x, y, c));
	endtask

	// one config transfer; only called with the pipeline empty
	task automatic write_reg(reg_index_t idx, logic [8:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_SECTOR_COUNT: cur_sectors = data[3:0];
			REG_EATEN:        cur_eaten = data[3:0];
			REG_CENTER_X:     cur_cx = data;
			REG_CENTER_Y:     cur_cy = data;
			REG_RADIUS:       cur_radius = data;
			REG_ERASE_COLOR:  cur_erase = data[3:0];
			default:          ; // unused indexes change nothing
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// hold the input until every predicted result has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	// reset settings: center pixel ties everywhere, the top of the rim, just past it,
	// a right-hand tie between two sectors, pixels off the frame and one at the frame edge
	task automatic test_defaults();
		send_pixel(9'd200, 9'd200, 4'd5);
		send_pixel(9'd200, 9'd12, 4'd3);
		send_pixel(9'd200, 9'd11, 4'd15);
		send_pixel(9'd388, 9'd200, 4'd0);
		send_pixel(9'd400, 9'd200, 4'd15);
		send_pixel(9'd511, 9'd511, 4'd9);
		send_pixel(9'd0, 9'd399, 4'd6);
		wait_drained();
	endtask

	// zero sectors act as one, more than nine saturate; upper data bits are dropped
	task automatic test_sector_count_limits();
		write_reg(REG_SECTOR_COUNT, 9'h1F0);
		write_reg(REG_EATEN, 9'h1F1);
		write_reg(REG_ERASE_COLOR, 9'h0F0);
		send_pixel(9'd300, 9'd250, 4'd12);
		send_pixel(9'd100, 9'd100, 4'd7);
		wait_drained();
		write_reg(REG_SECTOR_COUNT, 9'h00F);
		write_reg(REG_EATEN, 9'd9);
		send_pixel(9'd388, 9'd200, 4'd4);
		send_pixel(9'd210, 9'd190, 4'd2);
		wait_drained();
	endtask

	// nothing erased at zero, everything inside erased at or past the count,
	// writes to unused indexes ignored
	task automatic test_erase_limits();
		write_reg(REG_SECTOR_COUNT, 9'd4);
		write_reg(REG_EATEN, 9'd0);
		write_reg(REG_ERASE_COLOR, 9'h00F);
		send_pixel(9'd210, 9'd190, 4'd8);
		wait_drained();
		write_reg(REG_EATEN, 9'h00F);
		send_pixel(9'd200, 9'd300, 4'd8);
		wait_drained();
		write_reg(REG_UNUSED_6, 9'h1FF);
		write_reg(REG_UNUSED_7, 9'h000);
		send_pixel(9'd200, 9'd200, 4'd3);
		wait_drained();
	endtask

	// centers at both corners with the widest disc, then a disc of one pixel
	task automatic test_disc_extremes();
		write_reg(REG_SECTOR_COUNT, 9'd9);
		write_reg(REG_EATEN, 9'd5);
		write_reg(REG_CENTER_X, 9'd0);
		write_reg(REG_CENTER_Y, 9'd0);
		write_reg(REG_RADIUS, 9'h1FF);
		send_pixel(9'd399, 9'd399, 4'd1);
		send_pixel(9'd361, 9'd361, 4'd2);
		send_pixel(9'd0, 9'd0, 4'd3);
		wait_drained();
		write_reg(REG_CENTER_X, 9'h1FF);
		write_reg(REG_CENTER_Y, 9'h1FF);
		send_pixel(9'd399, 9'd399, 4'd4);
		send_pixel(9'd0, 9'd0, 4'd5);
		wait_drained();
		write_reg(REG_CENTER_X, 9'd100);
		write_reg(REG_CENTER_Y, 9'd50);
		write_reg(REG_RADIUS, 9'd0);
		send_pixel(9'd100, 9'd50, 4'd6);
		send_pixel(9'd101, 9'd50, 4'd7);
		wait_drained();
	endtask

	// fresh random settings, junk in the unused data bits
	task automatic randomize_settings();
		logic [3:0] count, eaten;
		logic [8:0] radius;
		count = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(1, 9)) : 4'($urandom);
		eaten = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, 10)) : 4'($urandom);
		radius = ($urandom_range(0, 99) < 20) ? 9'($urandom_range(0, 40)) : 9'($urandom);
		write_reg(REG_SECTOR_COUNT, {5'($urandom), count});
		write_reg(REG_EATEN, {5'($urandom), eaten});
		write_reg(REG_CENTER_X,
			($urandom_range(0, 99) < 85) ? 9'($urandom_range(0, 399)) : 9'($urandom));
		write_reg(REG_CENTER_Y,
			($urandom_range(0, 99) < 85) ? 9'($urandom_range(0, 399)) : 9'($urandom));
		write_reg(REG_RADIUS, radius);
		write_reg(REG_ERASE_COLOR, 9'($urandom));
		if ($urandom_range(0, 3) == 0)
			write_reg(($urandom_range(0, 1) == 0) ? REG_UNUSED_6 : REG_UNUSED_7, 9'($urandom));
	endtask

	// nearly half the pixels around the disc so sectors and erasing get exercised,
	// some anywhere in the frame and a few anywhere in the 9-bit range
	task automatic send_random_pixel();
		int sel, rad, ox, oy;
		logic [8:0] x, y;
		sel = $urandom_range(0, 99);
		rad = int'(cur_radius);
		if (sel < 45) begin
			ox = int'(cur_cx) + int'($urandom_range(0, 2 * rad)) - rad;
			oy = int'(cur_cy) + int'($urandom_range(0, 2 * rad)) - rad;
			x = 9'((ox < 0) ? 0 : (ox > FRAME_W - 1) ? FRAME_W - 1 : ox);
			y = 9'((oy < 0) ? 0 : (oy > FRAME_H - 1) ? FRAME_H - 1 : oy);
		end else if (sel < 88) begin
			x = 9'($urandom_range(0, FRAME_W - 1));
			y = 9'($urandom_range(0, FRAME_H - 1));
		end else begin
			x = 9'($urandom);
			y = 9'($urandom);
		end
		send_pixel(x, y, 4'($urandom));
	endtask

	// four flow-control phases, four settings each; one mid-stream drain in each phase
	task automatic test_random_traffic();
		int phase, setting, n;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 69; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 69; end
				default: begin idle_pct = 17; stall_pct = 17; end
			endcase
			for (setting = 0; setting < 4; setting++) begin
				wait_drained();
				randomize_settings();
				for (n = 0; n < SETTING_LEN; n++) begin
					// sender holds off until the pipeline has fully emptied
					if (setting == 2 && n == SETTING_LEN / 2)
						wait_drained();
					send_random_pixel();
				end
			end
		end
		wait_drained();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_sector_count_limits();
		test_erase_limits();
		test_disc_extremes();
		test_random_traffic();
		// let anything stray fall out of the pipeline
		repeat (2 * LATENCY) @(posedge clk);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
